// ===== sv/spp_pkg.sv =====
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types and constants of the scan-line palette token packer.
// ----------------------------------------------------------------------------
package spp_pkg;

    // Palette store and line geometry.
    localparam int TABLE_DEPTH    = 2048;
    localparam int TABLE_AW       = $clog2(TABLE_DEPTH);
    localparam int MAX_LINE_WIDTH = 1024;

    // Queue depths: command queue between front and back, and output queue.
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Request codes of an input beat.
    typedef enum logic [1:0] {
        REQ_TABLE = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_BLANK = 2'd2
    } t_req;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_BPP_MODE    = 3'd0,
        CFG_LINE_WIDTH  = 3'd1,
        CFG_TOK_RAW_RUN = 3'd2,
        CFG_TOK_RAW_ONE = 3'd3,
        CFG_TOK_RAW_TWO = 3'd4,
        CFG_TOK_CLR_RUN = 3'd5,
        CFG_TOK_EOL     = 3'd6
    } t_cfg_reg;

    // Packer operations issued by the sequencer.
    typedef enum logic [1:0] {
        PK_TOK   = 2'd0,
        PK_FLUSH = 2'd1,
        PK_EOL   = 2'd2
    } t_pk_op;

    // Input beat.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [10:0] table_index;
        logic [15:0] table_color;
        logic [7:0]  pixel_byte;
        logic        first_of_line;
        logic        last_of_line;
        logic [15:0] blank_color;
    } t_in_beat;

    // Output beat.
    typedef struct packed {
        logic [31:0] token_word;
        logic        line_end;
    } t_out_beat;

    // Configuration register file contents.
    typedef struct packed {
        logic [1:0]  bpp_mode;
        logic [10:0] line_width;
        logic [15:0] tok_raw_run;
        logic [15:0] tok_raw_one;
        logic [15:0] tok_raw_two;
        logic [15:0] tok_clr_run;
        logic [15:0] tok_eol;
    } t_cfg;

    // Classified command held in the queue between front and back.
    typedef struct packed {
        t_req                kind;
        logic [TABLE_AW-1:0] index;
        logic [15:0]         data;
        logic [7:0]          pixel_byte;
        logic                first;
        logic                last;
    } t_cmd;

    // One step for the packer: up to two tokens, a flush or an end-of-line word.
    typedef struct packed {
        logic        valid;
        logic        clear;
        t_pk_op      op;
        logic [1:0]  cnt;
        logic        mem0;
        logic        mem1;
        logic [15:0] const0;
        logic [15:0] const1;
    } t_step;

    // Palette address of pixel j of a byte: byte times pixels-per-byte plus j.
    function automatic logic [TABLE_AW-1:0] pix_addr(input logic [7:0] b,
                                                     input logic [1:0] mode,
                                                     input logic [2:0] j);
        logic [10:0] a;
        begin
            a = 11'd0;
            case (mode)
                2'd0:    a = {b, j};
                2'd1:    a = {1'b0, b, j[1:0]};
                2'd2:    a = {2'b00, b, j[0]};
                default: a = {3'b000, b};
            endcase
            pix_addr = TABLE_AW'(a);
        end
    endfunction

endpackage

// ===== sv/scanline_palette_token_packer_unit.sv =====
// ----------------------------------------------------------------------------
// scanline_palette_token_packer_unit
// Expands frame-buffer bytes through a 2048-entry 16-bit palette into a token
// stream packed two tokens to a 32-bit word. Palette writes are done by the
// back end; a pixel byte is issued as packer steps of up to two tokens each,
// bounded by the two palette read ports of the sequencer; a line end, also
// after a blank line, passes through the S_FIN, S_FLUSH and S_EOL states.
// Input beats queue up to four deep ahead of the sequencer and finished words
// up to four deep behind it, so either side may stall without halting the
// other. The palette is not cleared at reset and must be written before use.
// ----------------------------------------------------------------------------
module scanline_palette_token_packer_unit
    import spp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_beat    i_in_beat,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_beat   o_out_beat,
    input  logic        i_out_stall,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic        head_valid, head_pop, room;
    t_cmd        head;
    t_step       step;
    logic [15:0] rd0, rd1;

    // Configuration registers; they are read live, so the user must write them only
    // while the block is idle; the block itself does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bpp_mode    <= 2'd3;
            r_cfg.line_width  <= 11'd320;
            r_cfg.tok_raw_run <= '0;
            r_cfg.tok_raw_one <= '0;
            r_cfg.tok_raw_two <= '0;
            r_cfg.tok_clr_run <= '0;
            r_cfg.tok_eol     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_BPP_MODE:    r_cfg.bpp_mode    <= i_cfg_data[1:0];
                CFG_LINE_WIDTH:  r_cfg.line_width  <= i_cfg_data[10:0];
                CFG_TOK_RAW_RUN: r_cfg.tok_raw_run <= i_cfg_data;
                CFG_TOK_RAW_ONE: r_cfg.tok_raw_one <= i_cfg_data;
                CFG_TOK_RAW_TWO: r_cfg.tok_raw_two <= i_cfg_data;
                CFG_TOK_CLR_RUN: r_cfg.tok_clr_run <= i_cfg_data;
                CFG_TOK_EOL:     r_cfg.tok_eol     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: intake and command queue.
    spp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_beat    (i_in_beat),
        .o_in_stall   (o_in_stall),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_head_pop   (head_pop)
    );

    // Back end: sequencer with palette memory.
    spp_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_pop   (head_pop),
        .i_room       (room),
        .o_step       (step),
        .o_rd0        (rd0),
        .o_rd1        (rd1)
    );

    // Back end: word packer and output queue.
    spp_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_rd0       (rd0),
        .i_rd1       (rd1),
        .i_tok_eol   (r_cfg.tok_eol),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== sv/spp_front.sv =====
// ----------------------------------------------------------------------------
// spp_front
// Accepts input beats, classifies them into commands and queues them for the
// back end. Requests with an unused type code are taken and dropped here.
// ----------------------------------------------------------------------------
module spp_front
    import spp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_beat i_in_beat,
    output logic     o_in_stall,
    output logic     o_head_valid,
    output t_cmd     o_head,
    input  logic     i_head_pop
);

    t_cmd             r_q [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CQ_CW-1:0] r_cnt;
    t_cmd             cmd;
    logic             accept, push;

    // The queue refuses beats only when it is full.
    assign o_in_stall   = (r_cnt == CQ_CW'(CQ_DEPTH));
    assign accept       = i_in_valid && !o_in_stall;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rd_ptr];

    // Classify the beat into a command.
    always_comb begin
        cmd            = '0;
        push           = 1'b0;
        cmd.index      = TABLE_AW'(i_in_beat.table_index);
        cmd.pixel_byte = i_in_beat.pixel_byte;
        cmd.first      = i_in_beat.first_of_line;
        cmd.last       = i_in_beat.last_of_line;
        cmd.kind       = REQ_TABLE;
        cmd.data       = i_in_beat.table_color;
        unique case (i_in_beat.req_type)
            REQ_TABLE: begin
                cmd.kind = REQ_TABLE;
                cmd.data = i_in_beat.table_color;
                push     = accept;
            end
            REQ_PIXEL: begin
                cmd.kind = REQ_PIXEL;
                push     = accept;
            end
            REQ_BLANK: begin
                cmd.kind = REQ_BLANK;
                cmd.data = i_in_beat.blank_color;
                push     = accept;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_head_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !i_head_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_head_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/spp_seq.sv =====
// ----------------------------------------------------------------------------
// spp_seq
// Back-end sequencer. Owns the palette memory and the line position, walks
// each command and issues packer steps of up to two tokens per cycle, with
// two palette reads per cycle for the pixel colours, when there is room.
// ----------------------------------------------------------------------------
module spp_seq
    import spp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_head_valid,
    input  t_cmd        i_head,
    output logic        o_head_pop,
    input  logic        i_room,
    output t_step       o_step,
    output logic [15:0] o_rd0,
    output logic [15:0] o_rd1
);

    typedef enum logic [3:0] {
        S_BODY  = 4'b0001,
        S_FIN   = 4'b0010,
        S_FLUSH = 4'b0100,
        S_EOL   = 4'b1000
    } t_state;

    typedef struct packed {
        logic        mem;
        logic [15:0] cval;
        logic [2:0]  j;
    } t_slot;

    logic [15:0] r_mem [TABLE_DEPTH];
    logic [15:0] r_rd0, r_rd1;

    t_state      r_state, n_state;
    logic [3:0]  r_slot, n_slot;
    logic [10:0] r_pos, n_pos;
    t_step       r_step, n_step;

    logic [10:0]         w_eff, base, rem, pos_new;
    logic [3:0]          ppb, nv, n_tok;
    logic [15:0]         tok_w3, tok_w5;
    logic                go, last_pair, mem_we;
    t_slot               s0, s1;
    logic [TABLE_AW-1:0] addr0, addr1;

    // Token of one slot of a pixel byte's token list.
    function automatic t_slot slot_tok(input logic [3:0] q, input logic first,
                                       input logic no_pix, input logic [15:0] run,
                                       input logic [15:0] w3);
        t_slot s;
        begin
            s      = '0;
            s.mem  = 1'b1;
            s.cval = 16'd0;
            s.j    = q[2:0];
            if (first) begin
                // A line start with no room for pixels carries only the
                // header and the width token.
                if (q == 4'd0) begin
                    s.mem  = 1'b0;
                    s.cval = run;
                end else if (q == 4'd2 || (q == 4'd1 && no_pix)) begin
                    s.mem  = 1'b0;
                    s.cval = w3;
                end else if (q == 4'd1) begin
                    s.j = 3'd0;
                end else begin
                    s.j = 3'(q - 4'd2);
                end
            end
            slot_tok = s;
        end
    endfunction

    // Line geometry for the head byte.
    always_comb begin
        w_eff   = (i_cfg.line_width > 11'(MAX_LINE_WIDTH)) ? 11'(MAX_LINE_WIDTH)
                                                           : i_cfg.line_width;
        ppb     = 4'd8 >> i_cfg.bpp_mode;
        base    = i_head.first ? 11'd0 : r_pos;
        rem     = (base >= w_eff) ? 11'd0 : (w_eff - base);
        nv      = (rem < {7'd0, ppb}) ? rem[3:0] : ppb;
        n_tok   = i_head.first ? ((nv == 4'd0) ? 4'd2 : (nv + 4'd2)) : nv;
        pos_new = base + {7'd0, nv};
        tok_w3  = {5'd0, w_eff} - 16'd3;
        tok_w5  = {5'd0, w_eff} - 16'd5;
        s0      = slot_tok(r_slot, i_head.first, nv == 4'd0,
                           i_cfg.tok_raw_run, tok_w3);
        s1      = slot_tok(r_slot + 4'd1, i_head.first, nv == 4'd0,
                           i_cfg.tok_raw_run, tok_w3);
        addr0   = pix_addr(i_head.pixel_byte, i_cfg.bpp_mode, s0.j);
        addr1   = pix_addr(i_head.pixel_byte, i_cfg.bpp_mode, s1.j);
    end

    assign go        = i_room;
    assign last_pair = ({1'b0, r_slot} + 5'd2) >= {1'b0, n_tok};

    // Step sequencer.
    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_pos      = r_pos;
        n_step     = '0;
        n_step.op  = PK_TOK;
        o_head_pop = 1'b0;
        mem_we     = 1'b0;
        unique case (r_state)
            S_BODY: begin
                if (i_head_valid && go) begin
                    unique case (i_head.kind)
                        REQ_TABLE: begin
                            mem_we     = 1'b1;
                            o_head_pop = 1'b1;
                        end
                        REQ_PIXEL: begin
                            n_step.valid  = 1'b1;
                            n_step.clear  = i_head.first && (r_slot == 4'd0);
                            n_step.mem0   = s0.mem;
                            n_step.const0 = s0.cval;
                            n_step.mem1   = s1.mem;
                            n_step.const1 = s1.cval;
                            if (r_slot + 4'd1 < n_tok) begin
                                n_step.cnt = 2'd2;
                            end else if (r_slot < n_tok) begin
                                n_step.cnt = 2'd1;
                            end else begin
                                n_step.cnt = 2'd0;
                            end
                            if (last_pair) begin
                                o_head_pop = 1'b1;
                                n_slot     = 4'd0;
                                n_pos      = pos_new;
                                if (i_head.last) begin
                                    n_state = S_FIN;
                                end
                            end else begin
                                n_slot = r_slot + 4'd2;
                            end
                        end
                        REQ_BLANK: begin
                            n_step.valid = 1'b1;
                            n_step.cnt   = 2'd2;
                            n_step.clear = (r_slot == 4'd0);
                            case (r_slot)
                                4'd0: begin
                                    n_step.const0 = i_cfg.tok_clr_run;
                                    n_step.const1 = i_head.data;
                                end
                                4'd2: begin
                                    n_step.const0 = tok_w5;
                                    n_step.const1 = i_cfg.tok_raw_two;
                                end
                                default: begin
                                    n_step.const0 = i_head.data;
                                    n_step.const1 = i_head.data;
                                end
                            endcase
                            if (r_slot >= 4'd4) begin
                                o_head_pop = 1'b1;
                                n_slot     = 4'd0;
                                n_pos      = 11'd0;
                                n_state    = S_FIN;
                            end else begin
                                n_slot = r_slot + 4'd2;
                            end
                        end
                        default: begin
                            o_head_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_FIN: begin
                if (go) begin
                    n_step.valid  = 1'b1;
                    n_step.cnt    = 2'd2;
                    n_step.const0 = i_cfg.tok_raw_one;
                    n_step.const1 = 16'd0;
                    n_pos         = 11'd0;
                    n_state       = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (go) begin
                    n_step.valid = 1'b1;
                    n_step.op    = PK_FLUSH;
                    n_state      = S_EOL;
                end
            end
            S_EOL: begin
                if (go) begin
                    n_step.valid = 1'b1;
                    n_step.op    = PK_EOL;
                    n_state      = S_BODY;
                end
            end
            default: begin
                n_state = S_BODY;
            end
        endcase
    end

    // Palette memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_head.index] <= i_head.data;
        end
        r_rd0 <= r_mem[addr0];
        r_rd1 <= r_mem[addr1];
    end

    // Sequencer state and the step register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BODY;
            r_slot  <= '0;
            r_pos   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_pos   <= n_pos;
            r_step  <= n_step;
        end
    end

    assign o_step = r_step;
    assign o_rd0  = r_rd0;
    assign o_rd1  = r_rd1;

endmodule

// ===== sv/spp_pack.sv =====
// ----------------------------------------------------------------------------
// spp_pack
// Pairs tokens into 32-bit words, low half first, and holds finished words
// in a small output queue. Reports room so the sequencer never overruns it.
// ----------------------------------------------------------------------------
module spp_pack
    import spp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_step       i_step,
    input  logic [15:0] i_rd0,
    input  logic [15:0] i_rd1,
    input  logic [15:0] i_tok_eol,
    output logic        o_room,
    output logic        o_out_valid,
    output t_out_beat   o_out_beat,
    input  logic        i_out_stall
);

    t_out_beat        r_q [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [OQ_CW-1:0] r_cnt;
    logic             r_hf, n_hf;
    logic [15:0]      r_h, n_h;

    logic [15:0] t0, t1;
    logic        hf_eff, push, pop;
    t_out_beat   word;

    // A step in flight may still produce one word.
    assign o_room      = ({1'b0, r_cnt} + {{OQ_CW{1'b0}}, i_step.valid})
                         < (OQ_CW + 1)'(OQ_DEPTH);
    assign o_out_valid = (r_cnt != '0);
    assign o_out_beat  = r_q[r_rd_ptr];
    assign pop         = o_out_valid && !i_out_stall;

    // Token pairing.
    always_comb begin
        t0     = i_step.mem0 ? i_rd0 : i_step.const0;
        t1     = i_step.mem1 ? i_rd1 : i_step.const1;
        hf_eff = r_hf && !i_step.clear;
        n_hf   = r_hf;
        n_h    = r_h;
        push   = 1'b0;
        word   = '0;
        if (i_step.valid) begin
            n_hf = hf_eff;
            unique case (i_step.op)
                PK_TOK: begin
                    case (i_step.cnt)
                        2'd1: begin
                            if (hf_eff) begin
                                push            = 1'b1;
                                word.token_word = {t0, r_h};
                                n_hf            = 1'b0;
                                n_h             = 16'd0;
                            end else begin
                                n_h  = t0;
                                n_hf = 1'b1;
                            end
                        end
                        2'd2: begin
                            push = 1'b1;
                            if (hf_eff) begin
                                word.token_word = {t0, r_h};
                                n_h             = t1;
                                n_hf            = 1'b1;
                            end else begin
                                word.token_word = {t1, t0};
                                n_h             = 16'd0;
                                n_hf            = 1'b0;
                            end
                        end
                        default: begin
                            n_hf = hf_eff;
                        end
                    endcase
                end
                PK_FLUSH: begin
                    if (hf_eff) begin
                        push            = 1'b1;
                        word.token_word = {16'd0, r_h};
                    end
                    n_hf = 1'b0;
                    n_h  = 16'd0;
                end
                PK_EOL: begin
                    push            = 1'b1;
                    word.token_word = {i_tok_eol, 16'd0};
                    word.line_end   = 1'b1;
                end
                default: begin
                    n_hf = hf_eff;
                end
            endcase
        end
    end

    // Output queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= word;
        end
    end

    // Held half token and queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hf     <= 1'b0;
            r_h      <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_hf <= n_hf;
            r_h  <= n_h;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
